### src/dlr_pkg.sv
// Shared constants, opcodes and divider handshake types for the DDA line rasterizer.
// No dependencies; every other file imports this package.
`default_nettype none

package dlr_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  // Signed fixed point accumulator and slope widths.
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int SLOPE_BITS = FRAC_BITS + 2;

  // Dividend is |minor delta| shifted up by FRAC_BITS; one quotient bit per cycle.
  localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(NUM_BITS + 1);
  localparam int QUOT_BITS  = FRAC_BITS + 1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] dividend;
    logic [COORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quotient;
    logic                 inexact;
  } div_res_t;

endpackage

`default_nettype wire

### src/dlr_intf.sv
// Valid/ready channel interfaces: line requests in, pixels out.
// Depends on dlr_pkg for coordinate widths.
`default_nettype none

interface dlr_req_if import dlr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source(output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dlr_pix_if import dlr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source(output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink(input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

`default_nettype wire

### src/dlr_divider.sv
// Restoring divider for the slope: one quotient bit per cycle.
// Depends on dlr_pkg. Divisor must be nonzero; dividend must not exceed divisor.
`default_nettype none

module dlr_divider import dlr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_res_t      res
);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [NUM_BITS-1:0]   work;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] den;
  logic                  done;

  logic [COORD_BITS:0]   trial;
  logic                  fits;
  logic [COORD_BITS:0]   diff;

  assign trial = {rem, work[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the bottom of the dividend register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= {req.dividend, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      den  <= req.divisor;
    end else if (busy) begin
      work <= {work[NUM_BITS-2:0], fits};
      rem  <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    end
  end

  assign res.done     = done;
  assign res.quotient = work[QUOT_BITS-1:0];
  assign res.inexact  = |rem;

endmodule

`default_nettype wire

### src/dda_line_rasterizer_top.sv
// DDA line rasterizer top: request decode, line setup, step datapath, output register.
// Depends on dlr_pkg, dlr_intf (channel interfaces) and dlr_divider.
//
// A start request (opcode 0) loads two endpoints; the longer axis becomes the major
// axis and the endpoints are ordered so the major coordinate rises. The slope is
// computed by a restoring divider, one bit per cycle, so a start request holds off
// the next request until the divider is done and the slope is loaded; a line whose
// endpoints share a major coordinate skips the divider. Each step request (opcode 1)
// then returns one pixel and is taken every cycle while the pixel output register
// drains; the pixel that ends the line carries last_pixel. A step while no line is
// loaded returns nothing, and a start while a line is in progress drops the old line.
`default_nettype none

module dda_line_rasterizer_top import dlr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  dlr_req_if.sink   req,
  dlr_pix_if.source pix
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic                  state;
  logic                  line_busy;
  logic                  y_is_major;
  logic                  minor_neg;
  logic [COORD_BITS-1:0] major_position;
  logic [COORD_BITS-1:0] major_limit;
  logic [ACC_BITS-1:0]   minor_accumulator;
  logic [SLOPE_BITS-1:0] step_slope;

  logic                  out_valid;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_last;

  div_req_t div_req;
  div_res_t div_res;

  logic accept;
  logic start_acc;
  logic step_acc;
  logic emit;

  // Line setup
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  y_major_in;
  logic [COORD_BITS-1:0] maj_a, maj_b, min_a, min_b;
  logic                  swap;
  logic [COORD_BITS-1:0] maj0, maj1, min0, min1;
  logic [COORD_BITS-1:0] dmaj;
  logic                  dmin_neg;
  logic [COORD_BITS-1:0] dmin_mag;

  // Step datapath
  logic [COORD_BITS-1:0] minor_now;
  logic                  last_now;
  logic [SLOPE_BITS-1:0] slope_mag;
  logic [SLOPE_BITS-1:0] slope_new;

  assign req.ready = (state == ST_RUN) && (!out_valid || pix.ready);
  assign accept    = req.valid && req.ready;
  assign start_acc = accept && (req.opcode == OP_START);
  assign step_acc  = accept && (req.opcode == OP_STEP);
  assign emit      = step_acc && line_busy;

  always_comb begin
    adx        = (req.end_x >= req.start_x) ? req.end_x - req.start_x
                                            : req.start_x - req.end_x;
    ady        = (req.end_y >= req.start_y) ? req.end_y - req.start_y
                                            : req.start_y - req.end_y;
    y_major_in = ady > adx;
    maj_a      = y_major_in ? req.start_y : req.start_x;
    maj_b      = y_major_in ? req.end_y   : req.end_x;
    min_a      = y_major_in ? req.start_x : req.start_y;
    min_b      = y_major_in ? req.end_x   : req.end_y;
    swap       = maj_a > maj_b;
    maj0       = swap ? maj_b : maj_a;
    maj1       = swap ? maj_a : maj_b;
    min0       = swap ? min_b : min_a;
    min1       = swap ? min_a : min_b;
    dmaj       = maj1 - maj0;
    dmin_neg   = min0 > min1;
    dmin_mag   = dmin_neg ? min0 - min1 : min1 - min0;
  end

  assign div_req.start    = start_acc && (dmaj != '0);
  assign div_req.dividend = dmin_mag;
  assign div_req.divisor  = dmaj;

  dlr_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // Round toward plus infinity: bump a positive inexact quotient, negate a negative one.
  assign slope_mag = SLOPE_BITS'(div_res.quotient)
                   + SLOPE_BITS'(div_res.inexact && !minor_neg);
  assign slope_new = minor_neg ? -slope_mag : slope_mag;

  assign minor_now = minor_accumulator[FRAC_BITS +: COORD_BITS];
  assign last_now  = major_position == major_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_RUN;
      line_busy         <= 1'b0;
      y_is_major        <= 1'b0;
      minor_neg         <= 1'b0;
      major_position    <= '0;
      major_limit       <= '0;
      minor_accumulator <= '0;
      step_slope        <= '0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (start_acc) begin
            y_is_major        <= y_major_in;
            minor_neg         <= dmin_neg;
            major_position    <= maj0;
            major_limit       <= maj1;
            minor_accumulator <= {{(ACC_BITS-COORD_BITS-FRAC_BITS){1'b0}}, min0,
                                  {FRAC_BITS{1'b0}}};
            step_slope        <= '0;
            if (dmaj == '0) begin
              line_busy <= 1'b1;
            end else begin
              line_busy <= 1'b0;
              state     <= ST_DIV;
            end
          end else if (emit) begin
            if (last_now) begin
              line_busy <= 1'b0;
            end else begin
              major_position    <= major_position + 1'b1;
              minor_accumulator <= minor_accumulator
                + {{(ACC_BITS-SLOPE_BITS){step_slope[SLOPE_BITS-1]}}, step_slope};
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            step_slope <= slope_new;
            line_busy  <= 1'b1;
            state      <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // Output register: load on a pixel, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x    <= y_is_major ? minor_now : major_position;
      out_y    <= y_is_major ? major_position : minor_now;
      out_last <= last_now;
    end
  end

  assign pix.valid      = out_valid;
  assign pix.pixel_x    = out_x;
  assign pix.pixel_y    = out_y;
  assign pix.last_pixel = out_last;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIV))
    else $error("slope divider finished outside the divide state");

  a_no_line_while_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !line_busy)
    else $error("line marked busy before its slope is known");

  a_end_flags_last: assert property (@(posedge clk) disable iff (rst)
    (emit && last_now) |=> (out_valid && out_last && !line_busy))
    else $error("line ended without a flagged last pixel");

  a_pixel_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step_acc))
    else $error("pixel produced without a step request");
`endif

endmodule

`default_nettype wire
